// File: hw/rtl/psd_pkg.sv
package psd_pkg;

  localparam int COORD_BITS = 32;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int G_W        = PROD_W + 2;
  localparam int LO_W       = (SUM_W + 1) / 2;
  localparam int HI_W       = SUM_W - LO_W;
  localparam int NUM_W      = 2 * SUM_W;
  localparam int DIV_STEPS  = SUM_W;
  localparam int ROOT_W     = (SUM_W + 1) / 2;
  localparam int DIST_W     = COORD_BITS + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              degenerate;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic degenerate;
  } ctl_t;

  typedef enum logic [1:0] {
    SEL_DIV,
    SEL_START,
    SEL_END
  } sel_t;

endpackage

// File: hw/rtl/point_line_segment_distance.sv
// Pipeline: 6 front-end stages, 67 divider stages at one quotient bit each and
//   34 square-root stages lie between an input transfer and its result.
// Throughput: one item per cycle; the whole pipeline holds while out_stall is
//   high and a result waits.
// Reset: synchronous, active low; clears all valid bits and sets clamp_to_segment.
module point_line_segment_distance import psd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic              clamp_r;
  logic              adv;
  ctl_t              fr_ctl, dv_ctl, sq_ctl;
  logic [NUM_W-1:0]  fr_n;
  logic [SUM_W-1:0]  fr_m;
  logic [SUM_W-1:0]  dv_q;
  logic [ROOT_W-1:0] root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_r <= 1'b1;
    end else if (cfg_we) begin
      clamp_r <= cfg_wdata;
    end
  end

  assign adv      = !(sq_ctl.valid && out_stall);
  assign in_stall = !adv;

  psd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .clamp    (clamp_r),
    .ctl_out  (fr_ctl),
    .n_out    (fr_n),
    .m_out    (fr_m)
  );

  psd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .ctl_in  (fr_ctl),
    .n_in    (fr_n),
    .m_in    (fr_m),
    .ctl_out (dv_ctl),
    .q_out   (dv_q)
  );

  psd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .ctl_in   (dv_ctl),
    .d_in     (dv_q),
    .ctl_out  (sq_ctl),
    .root_out (root)
  );

  assign out_valid           = sq_ctl.valid;
  assign out_data.degenerate = sq_ctl.degenerate;
  assign out_data.distance   = (root[ROOT_W-1:DIST_W] != '0) ? '1 : root[DIST_W-1:0];

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");
  a_cfg_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> clamp_r == $past(cfg_wdata))
    else $error("clamp_to_segment not written");
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |-> !in_stall)
    else $error("input stalled while output transfers");
`endif

endmodule

// File: hw/rtl/psd_front.sv
module psd_front import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  in_item_t          in_data,
  input  logic              clamp,
  output ctl_t              ctl_out,
  output logic [NUM_W-1:0]  n_out,
  output logic [SUM_W-1:0]  m_out
);

  logic signed [COORD_BITS-1:0] pc [3];
  logic signed [COORD_BITS-1:0] sc [3];
  logic signed [COORD_BITS-1:0] ec [3];

  assign pc[0] = in_data.point_x;
  assign pc[1] = in_data.point_y;
  assign pc[2] = in_data.point_z;
  assign sc[0] = in_data.start_x;
  assign sc[1] = in_data.start_y;
  assign sc[2] = in_data.start_z;
  assign ec[0] = in_data.end_x;
  assign ec[1] = in_data.end_y;
  assign ec[2] = in_data.end_z;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic dg4_r, dg5_r, dg6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // stage 1: differences
  logic signed [DIFF_W-1:0] w_r [3];
  logic signed [DIFF_W-1:0] v_r [3];
  logic signed [DIFF_W-1:0] d_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        w_r[k] <= DIFF_W'(pc[k]) - DIFF_W'(sc[k]);
        v_r[k] <= DIFF_W'(pc[k]) - DIFF_W'(ec[k]);
        d_r[k] <= DIFF_W'(ec[k]) - DIFF_W'(sc[k]);
      end
    end
  end

  // stage 2: products
  logic signed [PROD_W-1:0] pww_r [3];
  logic signed [PROD_W-1:0] pdd_r [3];
  logic signed [PROD_W-1:0] pwd_r [3];
  logic signed [PROD_W-1:0] pvv_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pww_r[k] <= w_r[k] * w_r[k];
        pdd_r[k] <= d_r[k] * d_r[k];
        pwd_r[k] <= w_r[k] * d_r[k];
        pvv_r[k] <= v_r[k] * v_r[k];
      end
    end
  end

  // stage 3: dot products
  logic [SUM_W-1:0]        ww3_r, mm3_r, vv3_r;
  logic signed [G_W-1:0]   g3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ww3_r <= SUM_W'(pww_r[0][PROD_W-1:0]) + SUM_W'(pww_r[1][PROD_W-1:0])
             + SUM_W'(pww_r[2][PROD_W-1:0]);
      mm3_r <= SUM_W'(pdd_r[0][PROD_W-1:0]) + SUM_W'(pdd_r[1][PROD_W-1:0])
             + SUM_W'(pdd_r[2][PROD_W-1:0]);
      vv3_r <= SUM_W'(pvv_r[0][PROD_W-1:0]) + SUM_W'(pvv_r[1][PROD_W-1:0])
             + SUM_W'(pvv_r[2][PROD_W-1:0]);
      g3_r  <= G_W'(pwd_r[0]) + G_W'(pwd_r[1]) + G_W'(pwd_r[2]);
    end
  end

  // stage 4: case selection and partial products
  logic                 g_le0, g_ge_m, degen_nxt;
  sel_t                 sel_nxt;
  logic signed [G_W-1:0] g_neg;
  logic [SUM_W-1:0]     ag;

  always_comb begin
    g_le0     = g3_r[G_W-1] || (g3_r == '0);
    g_ge_m    = g3_r >= $signed({1'b0, mm3_r});
    degen_nxt = (mm3_r == '0);
    g_neg     = -g3_r;
    ag        = g3_r[G_W-1] ? g_neg[SUM_W-1:0] : g3_r[SUM_W-1:0];
    if (degen_nxt || (clamp && g_le0)) begin
      sel_nxt = SEL_START;
    end else if (clamp && g_ge_m) begin
      sel_nxt = SEL_END;
    end else begin
      sel_nxt = SEL_DIV;
    end
  end

  logic [2*LO_W-1:0]      mll_r, gll_r;
  logic [LO_W+HI_W-1:0]   mlh_r, mhl_r, glh_r;
  logic [2*HI_W-1:0]      mhh_r, ghh_r;
  logic [SUM_W-1:0]       ww4_r, mm4_r, vv4_r;
  sel_t                   sel4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mll_r  <= ww3_r[LO_W-1:0] * mm3_r[LO_W-1:0];
      mlh_r  <= ww3_r[LO_W-1:0] * mm3_r[SUM_W-1:LO_W];
      mhl_r  <= ww3_r[SUM_W-1:LO_W] * mm3_r[LO_W-1:0];
      mhh_r  <= ww3_r[SUM_W-1:LO_W] * mm3_r[SUM_W-1:LO_W];
      gll_r  <= ag[LO_W-1:0] * ag[LO_W-1:0];
      glh_r  <= ag[LO_W-1:0] * ag[SUM_W-1:LO_W];
      ghh_r  <= ag[SUM_W-1:LO_W] * ag[SUM_W-1:LO_W];
      ww4_r  <= ww3_r;
      mm4_r  <= mm3_r;
      vv4_r  <= vv3_r;
      sel4_r <= sel_nxt;
      dg4_r  <= degen_nxt;
    end
  end

  // stage 5: full products
  logic [NUM_W-1:0] p1_r, p2_r;
  logic [SUM_W-1:0] ww5_r, mm5_r, vv5_r;
  sel_t             sel5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= (NUM_W'(mhh_r) << (2 * LO_W)) + (NUM_W'(mlh_r) << LO_W)
              + (NUM_W'(mhl_r) << LO_W) + NUM_W'(mll_r);
      p2_r   <= (NUM_W'(ghh_r) << (2 * LO_W)) + (NUM_W'(glh_r) << (LO_W + 1))
              + NUM_W'(gll_r);
      ww5_r  <= ww4_r;
      mm5_r  <= mm4_r;
      vv5_r  <= vv4_r;
      sel5_r <= sel4_r;
      dg5_r  <= dg4_r;
    end
  end

  // stage 6: dividend and divisor
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] n_nxt;
  logic [SUM_W-1:0] m_nxt;
  logic [NUM_W-1:0] n6_r;
  logic [SUM_W-1:0] m6_r;

  always_comb begin
    num = (p1_r >= p2_r) ? (p1_r - p2_r) : '0;
    case (sel5_r)
      SEL_START: begin
        n_nxt = NUM_W'(ww5_r);
        m_nxt = SUM_W'(1);
      end
      SEL_END: begin
        n_nxt = NUM_W'(vv5_r);
        m_nxt = SUM_W'(1);
      end
      default: begin
        n_nxt = num;
        m_nxt = mm5_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n6_r  <= n_nxt;
      m6_r  <= m_nxt;
      dg6_r <= dg5_r;
    end
  end

  assign ctl_out = '{valid: v6_r, degenerate: dg6_r};
  assign n_out   = n6_r;
  assign m_out   = m6_r;

endmodule

// File: hw/rtl/psd_div.sv
module psd_div import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ctl_t              ctl_in,
  input  logic [NUM_W-1:0]  n_in,
  input  logic [SUM_W-1:0]  m_in,
  output ctl_t              ctl_out,
  output logic [SUM_W-1:0]  q_out
);

  logic [SUM_W-1:0] rem_r [DIV_STEPS];
  logic [SUM_W-1:0] lo_r  [DIV_STEPS];
  logic [SUM_W-1:0] q_r   [DIV_STEPS];
  logic [SUM_W-1:0] m_r   [DIV_STEPS];
  ctl_t             c_r   [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [SUM_W-1:0] rem_s, lo_s, q_s, m_s;
    ctl_t             c_s;
    logic [SUM_W+1:0] diff;
    logic             borrow;

    if (i == 0) begin : g_first
      assign rem_s = n_in[NUM_W-1:SUM_W];
      assign lo_s  = n_in[SUM_W-1:0];
      assign q_s   = '0;
      assign m_s   = m_in;
      assign c_s   = ctl_in;
    end else begin : g_next
      assign rem_s = rem_r[i-1];
      assign lo_s  = lo_r[i-1];
      assign q_s   = q_r[i-1];
      assign m_s   = m_r[i-1];
      assign c_s   = c_r[i-1];
    end

    assign diff   = {1'b0, rem_s, lo_s[SUM_W-1]} - {2'b00, m_s};
    assign borrow = diff[SUM_W+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_r[i].valid <= 1'b0;
      end else if (en) begin
        c_r[i].valid <= c_s.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[i].degenerate <= c_s.degenerate;
        rem_r[i] <= borrow ? {rem_s[SUM_W-2:0], lo_s[SUM_W-1]} : diff[SUM_W-1:0];
        lo_r[i]  <= {lo_s[SUM_W-2:0], 1'b0};
        q_r[i]   <= {q_s[SUM_W-2:0], ~borrow};
        m_r[i]   <= m_s;
      end
    end
  end

  assign ctl_out = c_r[DIV_STEPS-1];
  assign q_out   = q_r[DIV_STEPS-1];

endmodule

// File: hw/rtl/psd_sqrt.sv
module psd_sqrt import psd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ctl_t               ctl_in,
  input  logic [SUM_W-1:0]   d_in,
  output ctl_t               ctl_out,
  output logic [ROOT_W-1:0]  root_out
);

  localparam int TW = SUM_W + 3;

  logic [SUM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  ctl_t              c_r    [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    localparam int B = ROOT_W - 1 - i;
    logic [SUM_W-1:0]  rem_s;
    logic [ROOT_W-1:0] root_s;
    ctl_t              c_s;
    logic [TW-1:0]     trial;
    logic              take;

    if (i == 0) begin : g_first
      assign rem_s  = d_in;
      assign root_s = '0;
      assign c_s    = ctl_in;
    end else begin : g_next
      assign rem_s  = rem_r[i-1];
      assign root_s = root_r[i-1];
      assign c_s    = c_r[i-1];
    end

    assign trial = (TW'(root_s) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = TW'(rem_s) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_r[i].valid <= 1'b0;
      end else if (en) begin
        c_r[i].valid <= c_s.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[i].degenerate <= c_s.degenerate;
        rem_r[i]  <= take ? (rem_s - trial[SUM_W-1:0]) : rem_s;
        root_r[i] <= take ? (root_s | (ROOT_W'(1) << B)) : root_s;
      end
    end
  end

  assign ctl_out  = c_r[ROOT_W-1];
  assign root_out = root_r[ROOT_W-1];

endmodule

// File: tb/point_line_segment_distance_checker.sv
`timescale 1ns / 100ps
module point_line_segment_distance_checker import psd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output int        errors,
  output int        pending
);

  typedef logic signed [159:0] wide_t;

  out_item_t expected_distances[$];
  bit        segment_mode;

  initial errors = 0;
  assign pending = expected_distances.size();

  function automatic wide_t dot3(longint a0, longint a1, longint a2,
                                 longint b0, longint b1, longint b2);
    wide_t x0, x1, x2, y0, y1, y2;
    x0 = a0; x1 = a1; x2 = a2;
    y0 = b0; y1 = b1; y2 = b2;
    return x0 * y0 + x1 * y1 + x2 * y2;
  endfunction

  function automatic out_item_t predict_distance(in_item_t it, bit seg);
    longint wx, wy, wz, vx, vy, vz, dx, dy, dz;
    wide_t ww, mm, g, num, sq;
    logic [159:0] root, cand;
    out_item_t res;
    wx = longint'(it.point_x) - longint'(it.start_x);
    wy = longint'(it.point_y) - longint'(it.start_y);
    wz = longint'(it.point_z) - longint'(it.start_z);
    vx = longint'(it.point_x) - longint'(it.end_x);
    vy = longint'(it.point_y) - longint'(it.end_y);
    vz = longint'(it.point_z) - longint'(it.end_z);
    dx = longint'(it.end_x) - longint'(it.start_x);
    dy = longint'(it.end_y) - longint'(it.start_y);
    dz = longint'(it.end_z) - longint'(it.start_z);
    ww = dot3(wx, wy, wz, wx, wy, wz);
    mm = dot3(dx, dy, dz, dx, dy, dz);
    g  = dot3(wx, wy, wz, dx, dy, dz);
    res.degenerate = 1'b0;
    if (mm == 0) begin
      res.degenerate = 1'b1;
      sq = ww;
    end else if (seg && g <= 0) begin
      sq = ww;
    end else if (seg && g >= mm) begin
      sq = dot3(vx, vy, vz, vx, vy, vz);
    end else begin
      num = ww * mm - g * g;
      if (num < 0) num = 0;
      sq = num / mm;
    end
    root = '0;
    for (int b = 52; b >= 0; b--) begin
      cand = root | (160'd1 << b);
      if (cand * cand <= sq) root = cand;
    end
    if (root > {DIST_W{1'b1}}) root = {DIST_W{1'b1}};
    res.distance = root[DIST_W-1:0];
    return res;
  endfunction

  task automatic report(string what);
    $display("%0t: distance check: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      segment_mode = 1'b1;
      expected_distances.delete();
    end else begin
      if (cfg_we) segment_mode = cfg_wdata;
      if (in_valid && !in_stall)
        expected_distances.push_back(predict_distance(in_data, segment_mode));
      if (out_valid && !out_stall) begin
        if (expected_distances.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = expected_distances.pop_front();
          if (out_data.distance !== want.distance)
            report($sformatf("distance got %0d want %0d",
                             out_data.distance, want.distance));
          if (out_data.degenerate !== want.degenerate)
            report($sformatf("degenerate got %0b want %0b",
                             out_data.degenerate, want.degenerate));
        end
      end
    end
  end

endmodule

// File: tb/point_line_segment_distance_tb.sv
`timescale 1ns / 100ps
module point_line_segment_distance_tb;
  import psd_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  int        errors;
  int        pending;
  int        idle_mode = 0;

  always #1 clk = ~clk;

  point_line_segment_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  point_line_segment_distance_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  function automatic bit idle_now(bit sender);
    case (idle_mode)
      1: return sender && $urandom_range(0, 99) < 69;
      2: return !sender && $urandom_range(0, 99) < 69;
      3: return $urandom_range(0, 99) < 19;
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) out_stall <= idle_now(1'b0);

  task automatic send(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (idle_now(1'b1)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_and_write(bit seg);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= seg;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(bit near);
    if (near) return 32'($signed($urandom_range(0, 4000)) - 2000) <<< $urandom_range(0, 14);
    return $urandom;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    bit near;
    near = $urandom_range(0, 3) != 0;
    it.point_x = rand_coord(near); it.point_y = rand_coord(near);
    it.point_z = rand_coord(near);
    it.start_x = rand_coord(near); it.start_y = rand_coord(near);
    it.start_z = rand_coord(near);
    it.end_x = rand_coord(near); it.end_y = rand_coord(near);
    it.end_z = rand_coord(near);
    if ($urandom_range(0, 19) == 0) begin
      it.end_x = it.start_x; it.end_y = it.start_y; it.end_z = it.start_z;
    end
    return it;
  endfunction

  function automatic in_item_t line_item(int px, int sx, int ex);
    in_item_t it;
    it = '0;
    it.point_x = px; it.start_x = sx; it.end_x = ex;
    it.point_y = 32'sh0001_0000;
    return it;
  endfunction

  task automatic directed();
    in_item_t it;
    it = '0;
    send(it);
    it = {9{32'h7fff_ffff}};
    send(it);
    it = {9{32'h8000_0000}};
    send(it);
    it = {{3{32'h7fff_ffff}}, {6{32'h8000_0000}}};
    send(it);
    it = {{3{32'h8000_0000}}, {3{32'h7fff_ffff}}, {3{32'h8000_0000}}};
    send(it);
    it = {{3{32'h7fff_ffff}}, {3{32'h8000_0000}}, {3{32'h7fff_ffff}}};
    send(it);
    it = {{3{32'h8000_0000}}, {3{32'h7fff_ffff}}, {3{32'h7fff_ffff}}};
    send(it);
    send(line_item(-32'sh0005_0000, 0, 32'sh0004_0000));
    send(line_item(0, 0, 32'sh0004_0000));
    send(line_item(32'sh0002_0000, 0, 32'sh0004_0000));
    send(line_item(32'sh0004_0000, 0, 32'sh0004_0000));
    send(line_item(32'sh0009_0000, 0, 32'sh0004_0000));
    send(line_item(32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000));
    send(line_item(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send(line_item(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send(line_item(32'sh0000_0001, 0, 32'sh0000_0003));
  endtask

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    drain_and_write(1'b0);
    directed();
    for (int phase = 0; phase < 8; phase++) begin
      drain_and_write(phase[0]);
      idle_mode = phase / 2;
      repeat (200) send(rand_item());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
